>>> src/tsrf_pkg.sv
// ----------------------------------------------------------------------------
// tsrf_pkg - shared definitions for the temperature scratchpad report filter
// Register indexes, sanitizing limits, conversion constants and the
// bytewise CRC-8 step used by the filter.
// ----------------------------------------------------------------------------
package tsrf_pkg;

   // Scratchpad length
   localparam int PAD_BYTES_DEF = 9;

   // Configuration register indexes
   localparam int CSR_ADDR_W = 2;
   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_SENSOR_KIND = 2'd0,
      CSR_MIN_INTERVAL = 2'd1,
      CSR_MAX_INTERVAL = 2'd2,
      CSR_MIN_DELTA = 2'd3
   } csr_addr_type;
   localparam int CSR_DATA_W = 12;

   // Input kinds
   localparam logic ACTION_TICK = 1'b0;
   localparam logic ACTION_BYTE = 1'b1;

   // Elapsed-time counter
   localparam int MS_W = 22;
   localparam logic [MS_W-1:0] MS_MAX = '1;

   // Sanitizing limits
   localparam logic [11:0] INTERVAL_LOW = 12'd5;
   localparam logic [11:0] INTERVAL_HIGH = 12'd3600;
   localparam logic [11:0] MIN_INTERVAL_SUBST = 12'd10;
   localparam logic [11:0] MAX_INTERVAL_SUBST = 12'd150;
   localparam logic [7:0] DELTA_HIGH = 8'd250;
   localparam logic [7:0] DELTA_SUBST = 8'd5;
   localparam logic [9:0] MS_PER_S = 10'd1000;
   localparam logic [3:0] DELTA_SCALE = 4'd10;

   // Conversion constants
   localparam logic [15:0] EXT_MASK = 16'hfffe;
   localparam logic [15:0] EXT_BIAS = 16'd12;
   localparam logic signed [15:0] CENTI_PER_DEG = 16'sd100;
   localparam logic [15:0] FRAC_HALF = 16'd50;
   localparam logic [15:0] FRAC_QUARTER = 16'd25;
   localparam logic [15:0] FRAC_EIGHTH = 16'd13;
   localparam logic [15:0] FRAC_SIXTEENTH = 16'd6;

   // Resolution codes in bits 6..5 of the configuration byte
   localparam logic [1:0] RES_12 = 2'b11;
   localparam logic [1:0] RES_11 = 2'b10;
   localparam logic [1:0] RES_10 = 2'b01;

   // Reflected CRC-8 polynomial
   localparam logic [7:0] CRC_POLY = 8'h8c;

   // One byte through the reflected CRC-8, low bit first
   function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
      logic [7:0] c;
      logic [7:0] d;
      logic       mix;
      c = crc;
      d = data;
      for (int k = 0; k < 8; k++) begin
         mix = c[0] ^ d[0];
         c = c >> 1;
         if (mix) begin
            c = c ^ CRC_POLY;
         end
         d = d >> 1;
      end
      return c;
   endfunction

endpackage

>>> src/temp_scratchpad_report_filter.sv
// ----------------------------------------------------------------------------
// temp_scratchpad_report_filter - scratchpad check, conversion and report gate
// Collects scratchpad bytes, checks their CRC-8, converts the reading to
// hundredths of a degree and decides whether it is to be reported.
// ----------------------------------------------------------------------------
// The block takes one transaction per clock cycle: a millisecond tick or a
// scratchpad byte. Each transaction is held in the input register and is
// then processed by a single pass of logic that writes the result register,
// so a result is written from the last byte of a scratchpad as it leaves the
// input register. Ticks and all but the last byte give no result.
// The sustained rate of one transaction per cycle is held as long as the
// result side takes its results; a result waiting in the result register
// stalls the input only when the next transaction would produce another.
// There is no clearing pass after reset. The configuration registers are
// sanitized where they are used, so any written value is legal.
module temp_scratchpad_report_filter #(
   parameter int PAD_BYTES = tsrf_pkg::PAD_BYTES_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   // Input stream
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [7:0]                      req_tdata,  // [7:0] pad_byte
   input  logic                            req_tuser,  // [0] action
   // Result stream
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [15:0]                     rsp_tdata,  // [14:0] centi_celsius, [15] zero
   output logic [1:0]                      rsp_tuser,  // [0] report_now, [1] crc_bad
   // Configuration write port
   input  logic                            csr_we,
   input  logic [tsrf_pkg::CSR_ADDR_W-1:0] csr_addr,
   input  logic [tsrf_pkg::CSR_DATA_W-1:0] csr_wdata
);

   localparam int CNT_W = $clog2(PAD_BYTES);
   localparam logic [CNT_W-1:0] LAST_IDX = CNT_W'(PAD_BYTES - 1);

   // Configuration registers
   logic        kind_ff;
   logic [11:0] min_int_ff;
   logic [11:0] max_int_ff;
   logic [7:0]  delta_ff;

   // Input register
   logic        s1_valid_ff, s1_valid_in;
   logic        s1_action_ff;
   logic [7:0]  s1_byte_ff;

   // Block state
   logic [CNT_W-1:0]           count_ff, count_in;
   logic [7:0]                 crc_ff, crc_in;
   logic [7:0]                 pad_ff [PAD_BYTES];
   logic [tsrf_pkg::MS_W-1:0]  ms_ff, ms_in;
   logic signed [15:0]         last_ff, last_in;

   // Result register
   logic        out_valid_ff, out_valid_in;
   logic [14:0] out_centi_ff;
   logic        out_report_ff;
   logic        out_bad_ff;

   // Processing signals
   logic        s1_go;
   logic        frame_end;
   logic        out_free;
   logic [7:0]  crc_next;
   logic [15:0] raw;
   logic [15:0] raw_ext;
   logic [15:0] raw_adj;
   logic signed [15:0] whole;
   logic signed [15:0] centi;
   logic signed [16:0] diff_s;
   logic [15:0] diff;
   logic [11:0] mn;
   logic [11:0] mx_pre;
   logic [11:0] mx;
   logic [7:0]  dl;
   logic [tsrf_pkg::MS_W-1:0] mn_ms;
   logic [tsrf_pkg::MS_W-1:0] mx_ms;
   logic [11:0] dl_scaled;
   logic        send;

   // Write configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         kind_ff    <= 1'b0;
         min_int_ff <= '0;
         max_int_ff <= '0;
         delta_ff   <= '0;
      end else if (csr_we) begin
         case (csr_addr)
            tsrf_pkg::CSR_SENSOR_KIND:  kind_ff    <= csr_wdata[0];
            tsrf_pkg::CSR_MIN_INTERVAL: min_int_ff <= csr_wdata[11:0];
            tsrf_pkg::CSR_MAX_INTERVAL: max_int_ff <= csr_wdata[11:0];
            tsrf_pkg::CSR_MIN_DELTA:    delta_ff   <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   // Handshake: a held transaction advances unless it needs a busy result slot
   assign out_free  = !out_valid_ff || rsp_tready;
   assign frame_end = (s1_action_ff == tsrf_pkg::ACTION_BYTE) && (count_ff == LAST_IDX);
   assign s1_go     = s1_valid_ff && (!frame_end || out_free);
   assign req_tready = !s1_valid_ff || s1_go;

   // Capture the input transaction
   assign s1_valid_in = req_tready ? req_tvalid : s1_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         s1_action_ff <= req_tuser;
         s1_byte_ff   <= req_tdata;
      end
   end

   // Sanitize the configuration
   always_comb begin
      dl = (delta_ff > tsrf_pkg::DELTA_HIGH) ? tsrf_pkg::DELTA_SUBST : delta_ff;
      mn = min_int_ff;
      if (mn != '0 && (mn < tsrf_pkg::INTERVAL_LOW || mn > tsrf_pkg::INTERVAL_HIGH)) begin
         mn = tsrf_pkg::MIN_INTERVAL_SUBST;
      end
      mx_pre = max_int_ff;
      if (mx_pre != '0 &&
          (mx_pre < tsrf_pkg::INTERVAL_LOW || mx_pre > tsrf_pkg::INTERVAL_HIGH)) begin
         mx_pre = tsrf_pkg::MAX_INTERVAL_SUBST;
      end
      mx = (mx_pre != '0 && mx_pre < mn) ? '0 : mx_pre;
      mn_ms     = {10'd0, mn} * {12'd0, tsrf_pkg::MS_PER_S};
      mx_ms     = {10'd0, mx} * {12'd0, tsrf_pkg::MS_PER_S};
      dl_scaled = {4'd0, dl} * {8'd0, tsrf_pkg::DELTA_SCALE};
   end

   // Convert the stored reading
   always_comb begin
      raw     = {pad_ff[1], pad_ff[0]};
      raw_ext = 16'(((raw & tsrf_pkg::EXT_MASK) << 3) + tsrf_pkg::EXT_BIAS
                    - {8'd0, pad_ff[6]});
      raw_adj = raw;
      if (kind_ff) begin
         raw_adj = raw_ext;
      end else begin
         case (pad_ff[4][6:5])
            tsrf_pkg::RES_12: raw_adj = raw;
            tsrf_pkg::RES_11: raw_adj = {raw[15:1], 1'b0};
            tsrf_pkg::RES_10: raw_adj = {raw[15:2], 2'b00};
            default:          raw_adj = {raw[15:3], 3'b000};
         endcase
      end
      whole = {{8{raw_adj[11]}}, raw_adj[11:4]};
      centi = 16'(whole * tsrf_pkg::CENTI_PER_DEG);
      if (raw_adj[3]) centi = centi + $signed(tsrf_pkg::FRAC_HALF);
      if (raw_adj[2]) centi = centi + $signed(tsrf_pkg::FRAC_QUARTER);
      if (raw_adj[1]) centi = centi + $signed(tsrf_pkg::FRAC_EIGHTH);
      if (raw_adj[0]) centi = centi + $signed(tsrf_pkg::FRAC_SIXTEENTH);
   end

   // Decide on a report
   always_comb begin
      diff_s = 17'(centi) - 17'(last_ff);
      diff   = diff_s[16] ? 16'(-diff_s) : diff_s[15:0];
      send   = (mx != '0 && ms_ff >= mx_ms) || (dl != '0 && diff >= {4'd0, dl_scaled});
      if (mn != '0 && ms_ff < mn_ms) begin
         send = 1'b0;
      end
   end

   assign crc_next = tsrf_pkg::crc8_byte(crc_ff, s1_byte_ff);

   // Advance the block state
   always_comb begin
      count_in = count_ff;
      crc_in   = crc_ff;
      ms_in    = ms_ff;
      last_in  = last_ff;
      if (s1_go) begin
         if (s1_action_ff == tsrf_pkg::ACTION_TICK) begin
            if (ms_ff != tsrf_pkg::MS_MAX) begin
               ms_in = ms_ff + 1'b1;
            end
         end else if (frame_end) begin
            count_in = '0;
            crc_in   = '0;
            if (crc_next == 8'd0 && send) begin
               last_in = centi;
               ms_in   = '0;
            end
         end else begin
            count_in = count_ff + 1'b1;
            crc_in   = crc_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         crc_ff   <= '0;
         ms_ff    <= '0;
         last_ff  <= '0;
      end else begin
         count_ff <= count_in;
         crc_ff   <= crc_in;
         ms_ff    <= ms_in;
         last_ff  <= last_in;
      end
   end

   // Store scratchpad bytes
   always_ff @(posedge clock) begin
      if (s1_go && s1_action_ff == tsrf_pkg::ACTION_BYTE) begin
         pad_ff[count_ff] <= s1_byte_ff;
      end
   end

   // Load the result register
   assign out_valid_in = (s1_go && frame_end) ? 1'b1 : (rsp_tready ? 1'b0 : out_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_go && frame_end) begin
         if (crc_next != 8'd0) begin
            out_centi_ff  <= '0;
            out_report_ff <= 1'b0;
            out_bad_ff    <= 1'b1;
         end else begin
            out_centi_ff  <= centi[14:0];
            out_report_ff <= send;
            out_bad_ff    <= 1'b0;
         end
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {1'b0, out_centi_ff};
   assign rsp_tuser  = {out_bad_ff, out_report_ff};

`ifndef NO_ASSERTIONS
   // A failed check carries neither a reading nor a report
   a_bad_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[1] |-> rsp_tdata == 16'd0 && !rsp_tuser[0])
      else $error("crc_bad result carries data");

   // The byte count stays inside the scratchpad
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= LAST_IDX)
      else $error("byte count out of range");

   // A report restarts the interval counter and records the reading
   a_report_clears: assert property (@(posedge clock) disable iff (reset)
      s1_go && frame_end && crc_next == 8'd0 && send
      |=> ms_ff == '0 && last_ff[14:0] == rsp_tdata[14:0])
      else $error("report did not restart interval");

   // Input stalls only behind a held frame end with a waiting result
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> s1_valid_ff && frame_end && rsp_tvalid)
      else $error("input stalled without cause");
`endif

endmodule
